// ===== src/swa_pkg.sv =====
// shared constants and control types for the sliding window average block
// no dependencies
package swa_pkg;

  localparam int unsigned MAX_WINDOW  = 1024;
  localparam int unsigned SAMPLE_BITS = 32;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_start;
    logic load_out;
  } swa_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_room;
  } swa_status_t;

endpackage

// ===== src/swa_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module swa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/swa_div.sv =====
// unsigned restoring divider, one quotient bit per cycle
// no dependencies
module swa_div #(
  parameter int unsigned NUM_W = 42,
  parameter int unsigned DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   rem_shift;
  logic [DEN_W:0]   trial;

  assign rem_shift = {rem, quotient[NUM_W-1]};
  assign trial     = rem_shift - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NUM_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      den      <= divisor;
    end else if (busy) begin
      if (!trial[DEN_W]) begin
        rem      <= trial[DEN_W-1:0];
        quotient <= {quotient[NUM_W-2:0], 1'b1};
      end else begin
        rem      <= rem_shift[DEN_W-1:0];
        quotient <= {quotient[NUM_W-2:0], 1'b0};
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider finished without running");

endmodule

// ===== src/swa_datapath.sv =====
// window store, running sum, divider and output register
// depends on swa_pkg, swa_ram, swa_div
module swa_datapath #(
  parameter int unsigned MAX_WINDOW  = swa_pkg::MAX_WINDOW,
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  swa_pkg::swa_cmd_t                    cmd,
  output swa_pkg::swa_status_t                 status,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic                                 cfg_valid,
  input  logic [$clog2(MAX_WINDOW + 1)-1:0]    cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        average,
  output logic [$clog2(MAX_WINDOW + 1)-1:0]    held_count
);

  localparam int unsigned COUNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IDX_W   = MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SUM_W   = SAMPLE_BITS + $clog2(MAX_WINDOW);

  logic signed [SAMPLE_BITS-1:0] sample_reg;
  logic [COUNT_W-1:0]            window_size;
  logic [COUNT_W-1:0]            window_next;
  logic [COUNT_W-1:0]            fill_count;
  logic [IDX_W-1:0]              oldest_index;
  logic [COUNT_W-1:0]            oldest_inc;
  logic signed [SUM_W-1:0]       running_sum;
  logic signed [SUM_W-1:0]       running_sum_next;
  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic                          full;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  logic                          neg;
  logic [SUM_W-1:0]              sum_mag;
  logic                          div_done;
  logic [SUM_W-1:0]              quotient;
  logic [SUM_W-1:0]              quot_signed;

  assign full       = fill_count >= window_size;
  assign oldest_inc = COUNT_W'(oldest_index) + 1'b1;
  assign wr_en      = cmd.update;
  assign wr_addr    = full ? oldest_index : fill_count[IDX_W-1:0];

  always_comb begin
    if (full) begin
      running_sum_next = running_sum - SUM_W'(old_sample) + SUM_W'(sample_reg);
    end else begin
      running_sum_next = running_sum + SUM_W'(sample_reg);
    end
  end

  always_comb begin
    priority if (cfg_data == '0) begin
      window_next = COUNT_W'(1);
    end else if (cfg_data > COUNT_W'(MAX_WINDOW)) begin
      window_next = COUNT_W'(MAX_WINDOW);
    end else begin
      window_next = cfg_data;
    end
  end

  assign sum_mag     = running_sum[SUM_W-1] ? SUM_W'(-running_sum) : SUM_W'(running_sum);
  assign quot_signed = neg ? -quotient : quotient;

  swa_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(sample_reg),
    .rd_addr(oldest_index),
    .rd_data(old_sample)
  );

  swa_div #(
    .NUM_W(SUM_W),
    .DEN_W(COUNT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(sum_mag),
    .divisor (fill_count),
    .done    (div_done),
    .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= COUNT_W'(1);
      fill_count   <= '0;
      oldest_index <= '0;
      running_sum  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && window_next != window_size) begin
        window_size  <= window_next;
        fill_count   <= '0;
        oldest_index <= '0;
        running_sum  <= '0;
      end else if (cmd.update) begin
        running_sum <= running_sum_next;
        if (full) begin
          oldest_index <= (oldest_inc >= window_size) ? '0 : oldest_index + 1'b1;
        end else begin
          fill_count <= fill_count + 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_reg <= sample;
    end
    if (cmd.div_start) begin
      neg <= running_sum[SUM_W-1];
    end
    if (cmd.load_out) begin
      average    <= quot_signed[SAMPLE_BITS-1:0];
      held_count <= fill_count;
    end
  end

  assign status.div_done = div_done;
  assign status.out_room = !out_valid || out_ready;

  assert property (@(posedge clk) disable iff (rst) fill_count <= window_size)
    else $error("fill count beyond window size");

  assert property (@(posedge clk) disable iff (rst)
    oldest_index != '0 |-> fill_count == window_size)
    else $error("ring index moved before the window filled");

  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> fill_count != '0)
    else $error("division started with an empty window");

endmodule

// ===== src/swa_ctrl.sv =====
// sequencing state machine: accept, update, divide, deliver
// depends on swa_pkg
module swa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  swa_pkg::swa_status_t status,
  output swa_pkg::swa_cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    UPDATE,
    DIV_START,
    DIV_WAIT,
    DELIVER
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      in_ready <= 1'b1;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state    <= UPDATE;
            in_ready <= 1'b0;
          end
        end
        UPDATE: begin
          state <= DIV_START;
        end
        DIV_START: begin
          state <= DIV_WAIT;
        end
        DIV_WAIT: begin
          if (status.div_done) begin
            state <= DELIVER;
          end
        end
        DELIVER: begin
          if (status.out_room) begin
            state    <= IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd.accept    = in_valid && in_ready;
    cmd.update    = state == UPDATE;
    cmd.div_start = state == DIV_START;
    cmd.load_out  = state == DELIVER && status.out_room;
  end

  assert property (@(posedge clk) disable iff (rst) in_ready |-> state == IDLE)
    else $error("input ready outside idle");

endmodule

// ===== src/sliding_window_average.sv =====
// sliding window average: moving average of signed q16.16 samples over a ring store
// one item at a time; an input beat passes through accept, update, divider start, the
// bit-per-cycle divider and delivery; a new input beat is taken once the previous
// result sits in the output register
// reset clears count, index and sum and sets window_size to 1; no store clearing pass
// depends on swa_pkg, swa_ctrl, swa_datapath
module sliding_window_average #(
  parameter int unsigned MAX_WINDOW  = swa_pkg::MAX_WINDOW,
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             s_tvalid,
  output logic                                             s_tready,
  // sample
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0]           s_tdata,
  output logic                                             m_tvalid,
  input  logic                                             m_tready,
  // average, held_count
  output logic [((SAMPLE_BITS + $clog2(MAX_WINDOW + 1) + 7) / 8) * 8-1:0] m_tdata,
  input  logic                                             cfg_valid,
  output logic                                             cfg_ready,
  // window_size
  input  logic [$clog2(MAX_WINDOW + 1)-1:0]                cfg_data
);

  localparam int unsigned COUNT_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned OUT_W   = ((SAMPLE_BITS + COUNT_W + 7) / 8) * 8;

  swa_pkg::swa_cmd_t    cmd;
  swa_pkg::swa_status_t status;
  logic signed [SAMPLE_BITS-1:0] average;
  logic [COUNT_W-1:0]            held_count;

  assign cfg_ready = 1'b1;
  assign m_tdata   = OUT_W'({held_count, average});

  swa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  swa_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample    (s_tdata[SAMPLE_BITS-1:0]),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .average   (average),
    .held_count(held_count)
  );

endmodule
